// ===== hdl/dq_pkg.sv =====
// shared constants, types and codes for the double-ended queue
package dq_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 64;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int SUM_BITS  = CNT_BITS + 1;

    // stream widths, padded to whole bytes
    localparam int MODE_BITS   = 3;
    localparam int VALUE_BITS  = 64;
    localparam int IN_BITS     = MODE_BITS + VALUE_BITS;
    localparam int IN_BYTES    = (IN_BITS + 7) / 8;
    localparam int OUT_WORD    = 64;
    localparam int COUNT_BITS  = 7;
    localparam int STATUS_BITS = 2;
    localparam int OUT_BITS    = 2 * OUT_WORD + COUNT_BITS + 1 + STATUS_BITS;
    localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;
    localparam int OUT_PAD     = OUT_BYTES * 8 - OUT_BITS;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_REVERSE    = 3'd4,
        MODE_PEEK       = 3'd5
    } mode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LOAD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic read;
        logic load;
    } dq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dq_stat_t;

endpackage

// ===== hdl/dq_ram.sv =====
// generic ram: one write port, two registered read ports
module dq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [ABITS-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [ABITS-1:0] raddr_a,
    input  logic [ABITS-1:0] raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== hdl/dq_ctrl.sv =====
// controller state machine for the double-ended queue
module dq_ctrl
    import dq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dq_stat_t stat,
    output dq_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_READ;
            ST_READ: state_next = ST_LOAD;
            ST_LOAD:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = (state_reg == ST_IDLE);
        cmd.accept = (state_reg == ST_IDLE) && s_tvalid;
        cmd.exec   = (state_reg == ST_EXEC);
        cmd.read   = (state_reg == ST_READ);
        cmd.load   = (state_reg == ST_LOAD) && stat.out_free;
    end

endmodule

// ===== hdl/dq_datapath.sv =====
// ring pointers, slot store and output register of the double-ended queue
module dq_datapath
    import dq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dq_cmd_t                cmd,
    output dq_stat_t               stat,
    input  logic [MODE_BITS-1:0]   in_mode,
    input  logic [VALUE_BITS-1:0]  in_value,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [OUT_WORD-1:0]    out_front,
    output logic [OUT_WORD-1:0]    out_back,
    output logic [COUNT_BITS-1:0]  out_count,
    output logic                   out_empty,
    output logic [STATUS_BITS-1:0] out_status
);

    // latched input word
    mode_t                mode_reg;
    logic [WORD_BITS-1:0] value_reg;

    // queue control state
    logic [ADDR_BITS-1:0] head_reg;
    logic [ADDR_BITS-1:0] head_next;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;
    logic                 flip_reg;
    logic                 flip_next;
    status_t              status_reg;
    status_t              status_next;

    // output register
    logic                 out_valid_reg;
    logic [OUT_WORD-1:0]  front_reg;
    logic [OUT_WORD-1:0]  back_reg;
    logic [COUNT_BITS-1:0] count_out_reg;
    logic                 empty_reg;
    status_t              status_out_reg;

    // ram signals
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [ADDR_BITS-1:0] last_addr;
    logic [WORD_BITS-1:0] rd_first;
    logic [WORD_BITS-1:0] rd_last;

    logic                 is_full;
    logic                 is_empty;
    logic                 at_start;
    logic [ADDR_BITS-1:0] head_prev;
    logic [ADDR_BITS-1:0] head_succ;
    logic [SUM_BITS-1:0]  tail_sum;
    logic [ADDR_BITS-1:0] tail_addr;
    logic [SUM_BITS-1:0]  last_sum;
    logic [WORD_BITS-1:0] front_word;
    logic [WORD_BITS-1:0] back_word;

    assign is_full  = (count_reg == CNT_BITS'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign head_prev = (head_reg == '0) ? ADDR_BITS'(DEPTH - 1) : head_reg - 1'b1;
    assign head_succ = (head_reg == ADDR_BITS'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // slot just past the last entry
    assign tail_sum  = SUM_BITS'(head_reg) + SUM_BITS'(count_reg);
    assign tail_addr = (tail_sum >= SUM_BITS'(DEPTH)) ?
                       ADDR_BITS'(tail_sum - SUM_BITS'(DEPTH)) : ADDR_BITS'(tail_sum);

    // slot of the last entry, head itself when empty
    assign last_sum  = tail_sum - SUM_BITS'(1);
    always_comb
    begin
        if (is_empty)
        begin
            last_addr = head_reg;
        end
        else if (last_sum >= SUM_BITS'(DEPTH))
        begin
            last_addr = ADDR_BITS'(last_sum - SUM_BITS'(DEPTH));
        end
        else
        begin
            last_addr = ADDR_BITS'(last_sum);
        end
    end

    // command update
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        flip_next   = flip_reg;
        status_next = STATUS_OK;
        ram_we      = 1'b0;
        at_start    = 1'b0;
        ram_waddr   = tail_addr;
        unique case (mode_reg)
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
            begin
                at_start = flip_reg ? (mode_reg == MODE_PUSH_BACK)
                                    : (mode_reg == MODE_PUSH_FRONT);
                if (is_full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    ram_we     = cmd.exec;
                    count_next = count_reg + 1'b1;
                    if (at_start)
                    begin
                        head_next = head_prev;
                        ram_waddr = head_prev;
                    end
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK:
            begin
                at_start = flip_reg ? (mode_reg == MODE_POP_BACK)
                                    : (mode_reg == MODE_POP_FRONT);
                if (is_empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (at_start)
                    begin
                        head_next = head_succ;
                    end
                end
            end
            MODE_REVERSE:
            begin
                if (is_empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    flip_next = ~flip_reg;
                end
            end
            default:
            begin
                // peek and unused codes change nothing
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg  <= mode_t'(in_mode);
            value_reg <= in_value[WORD_BITS-1:0];
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            flip_reg  <= 1'b0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            flip_reg  <= flip_next;
        end
    end

    dq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (value_reg),
        .re      (cmd.read),
        .raddr_a (head_reg),
        .raddr_b (last_addr),
        .rdata_a (rd_first),
        .rdata_b (rd_last)
    );

    assign front_word = is_empty ? '0 : (flip_reg ? rd_last : rd_first);
    assign back_word  = is_empty ? '0 : (flip_reg ? rd_first : rd_last);

    assign stat.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            front_reg      <= OUT_WORD'(front_word);
            back_reg       <= OUT_WORD'(back_word);
            count_out_reg  <= COUNT_BITS'(count_reg);
            empty_reg      <= is_empty;
            status_out_reg <= status_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign out_front  = front_reg;
    assign out_back   = back_reg;
    assign out_count  = count_out_reg;
    assign out_empty  = empty_reg;
    assign out_status = status_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_BITS'(head_reg) < SUM_BITS'(DEPTH))
        else $error("head slot out of range");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(count_reg))
        else $error("entry count moved outside update step");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid_reg)
        else $error("loaded word not presented");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && empty_reg |-> (front_reg == '0) && (back_reg == '0))
        else $error("empty queue reports a word");

endmodule

// ===== hdl/double_ended_queue_core.sv =====
// top level of the double-ended queue: stream ports, controller and datapath
//
// Each command word is taken on s_tdata and gives one result word on m_tdata.
// A word runs through four steps: acceptance, pointer update with the slot
// write, a registered read of the first and last slots of the ring ram, and
// the load of the output register. s_tready is low from acceptance until the
// result has entered the output register, and a result held there by a low
// m_tready lets the next command be accepted and worked on, stalling only at
// the output load. Reverse only toggles a direction bit, no words move. The
// store needs no clearing after reset.
module double_ended_queue_core
    import dq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_BYTES*8-1:0]  s_tdata,  // mode[2:0], value[63:0], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_BYTES*8-1:0] m_tdata   // front_word[63:0], back_word[63:0],
                                             // entry_count[6:0], is_empty,
                                             // status[1:0], zero pad
);

    dq_cmd_t                cmd;
    dq_stat_t               stat;
    logic [OUT_WORD-1:0]    out_front;
    logic [OUT_WORD-1:0]    out_back;
    logic [COUNT_BITS-1:0]  out_count;
    logic                   out_empty;
    logic [STATUS_BITS-1:0] out_status;

    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_mode    (s_tdata[MODE_BITS-1:0]),
        .in_value   (s_tdata[IN_BITS-1:MODE_BITS]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_front  (out_front),
        .out_back   (out_back),
        .out_count  (out_count),
        .out_empty  (out_empty),
        .out_status (out_status)
    );

    assign m_tdata = {{OUT_PAD{1'b0}}, out_status, out_empty, out_count, out_back, out_front};

endmodule

// ===== test/tb_top.sv =====
// testbench for double_ended_queue_core: directed table then randomised command streams
`timescale 1ns / 100ps

module tb_top;
    import dq_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;
    localparam logic [WORD_BITS-1:0] ALL_ONES      = '1;

    localparam int RANDOM_ITEMS  = 800;
    localparam int PAUSE_AT      = 250;
    localparam int HOLD_AT       = 420;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_AFTER   = 650;
    localparam int DRAIN_CYCLES  = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int DIRECTED_ROWS = 21;

    typedef struct packed {
        logic [WORD_BITS-1:0]   front_word;
        logic [WORD_BITS-1:0]   back_word;
        logic [COUNT_BITS-1:0]  entry_count;
        logic                   is_empty;
        logic [STATUS_BITS-1:0] status;
    } dq_result_t;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [WORD_BITS-1:0] value;
        logic                 typed;
        dq_result_t           res;
    } cmd_row_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_BYTES*8-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_BYTES*8-1:0] m_tdata;

    // shadow copy of the ring
    logic [WORD_BITS-1:0] shadow_ring [DEPTH];
    logic [ADDR_BITS-1:0] shadow_head  = '0;
    logic [CNT_BITS-1:0]  shadow_count = '0;
    logic                 shadow_flip  = 1'b0;

    dq_result_t expected_results [$];
    int         error_count = 0;
    int         words_sent  = 0;
    bit         quiet       = 1'b0;
    bit         rx_hold     = 1'b0;

    cmd_row_t directed_rows [DIRECTED_ROWS] = '{
        '{MODE_PEEK,       64'd0, 1'b1, '{64'd0, 64'd0, 7'd0, 1'b1, STATUS_OK}},
        '{MODE_POP_FRONT,  64'd0, 1'b1, '{64'd0, 64'd0, 7'd0, 1'b1, STATUS_EMPTY}},
        '{MODE_POP_BACK,   64'd0, 1'b1, '{64'd0, 64'd0, 7'd0, 1'b1, STATUS_EMPTY}},
        '{MODE_REVERSE,    64'd0, 1'b1, '{64'd0, 64'd0, 7'd0, 1'b1, STATUS_EMPTY}},
        '{MODE_PUSH_FRONT, ALL_ONES, 1'b1, '{ALL_ONES, ALL_ONES, 7'd1, 1'b0, STATUS_OK}},
        '{MODE_REVERSE,    64'd0, 1'b1, '{ALL_ONES, ALL_ONES, 7'd1, 1'b0, STATUS_OK}},
        '{MODE_REVERSE,    64'd0, 1'b1, '{ALL_ONES, ALL_ONES, 7'd1, 1'b0, STATUS_OK}},
        '{MODE_PUSH_BACK,  64'd0, 1'b1, '{ALL_ONES, 64'd0, 7'd2, 1'b0, STATUS_OK}},
        '{MODE_REVERSE,    ALL_ONES, 1'b1, '{64'd0, ALL_ONES, 7'd2, 1'b0, STATUS_OK}},
        '{MODE_PUSH_FRONT, 64'h5555_5555_5555_5555, 1'b0, '0},
        '{MODE_PUSH_BACK,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{MODE_SPARE_LO,   ALL_ONES, 1'b0, '0},
        '{MODE_SPARE_HI,   64'd0, 1'b0, '0},
        '{MODE_POP_FRONT,  ALL_ONES, 1'b0, '0},
        '{MODE_POP_BACK,   64'd0, 1'b0, '0},
        '{MODE_PUSH_FRONT, 64'd1, 1'b0, '0},
        '{MODE_POP_BACK,   64'd0, 1'b0, '0},
        '{MODE_REVERSE,    64'd0, 1'b0, '0},
        '{MODE_POP_FRONT,  64'd0, 1'b0, '0},
        '{MODE_POP_BACK,   64'd0, 1'b1, '{64'd0, 64'd0, 7'd0, 1'b1, STATUS_OK}},
        '{MODE_POP_FRONT,  64'd0, 1'b1, '{64'd0, 64'd0, 7'd0, 1'b1, STATUS_EMPTY}}
    };

    double_ended_queue_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // applies one command to the shadow ring and returns the word it should report
    function automatic dq_result_t apply_command(input logic [MODE_BITS-1:0] md,
                                                 input logic [WORD_BITS-1:0] val);
        dq_result_t           r;
        logic                 at_start;
        logic [ADDR_BITS-1:0] idx;
        logic [WORD_BITS-1:0] first_word;
        logic [WORD_BITS-1:0] last_word;
        r = '0;
        r.status = STATUS_OK;
        case (md)
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
            begin
                if (shadow_count == DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    // a flipped ring swaps which physical end is the front
                    at_start = (md == MODE_PUSH_FRONT) ^ shadow_flip;
                    if (at_start)
                    begin
                        shadow_head = shadow_head - 1'b1;
                        shadow_ring[shadow_head] = val;
                    end
                    else
                    begin
                        idx = shadow_head + shadow_count[ADDR_BITS-1:0];
                        shadow_ring[idx] = val;
                    end
                    shadow_count = shadow_count + 1'b1;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK:
            begin
                if (shadow_count == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    at_start = (md == MODE_POP_FRONT) ^ shadow_flip;
                    if (at_start)
                        shadow_head = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            end
            MODE_REVERSE:
            begin
                if (shadow_count == 0)
                    r.status = STATUS_EMPTY;
                else
                    shadow_flip = ~shadow_flip;
            end
            default:
            begin
            end
        endcase
        if (shadow_count != 0)
        begin
            first_word = shadow_ring[shadow_head];
            idx = shadow_head + shadow_count[ADDR_BITS-1:0] - 1'b1;
            last_word = shadow_ring[idx];
            r.front_word = shadow_flip ? last_word : first_word;
            r.back_word  = shadow_flip ? first_word : last_word;
        end
        r.entry_count = shadow_count;
        r.is_empty    = (shadow_count == 0);
        return r;
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_word();
        logic [WORD_BITS-1:0] w;
        case ($urandom_range(0, 7))
            0: w = ALL_ONES;
            1: w = '0;
            2: w = 64'd1 << $urandom_range(0, WORD_BITS - 1);
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    function automatic logic [MODE_BITS-1:0] push_mode();
        return ($urandom_range(0, 1) != 0) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    endfunction

    function automatic logic [MODE_BITS-1:0] pop_mode();
        return ($urandom_range(0, 1) != 0) ? MODE_POP_BACK : MODE_POP_FRONT;
    endfunction

    function automatic logic [MODE_BITS-1:0] pick_mode();
        int roll;
        logic [MODE_BITS-1:0] md;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            md = push_mode();
        else if (roll < 80)
            md = pop_mode();
        else if (roll < 90)
            md = MODE_REVERSE;
        else
        begin
            case ($urandom_range(0, 2))
                0: md = MODE_SPARE_LO;
                1: md = MODE_SPARE_HI;
                default: md = MODE_PEEK;
            endcase
        end
        return md;
    endfunction

    // called at a rising edge; returns at the edge that took the word, or later after a random idle gap
    task automatic send_word(input logic [MODE_BITS-1:0] md, input logic [WORD_BITS-1:0] val,
                             input logic typed, input dq_result_t typed_res);
        logic [IN_BYTES*8-1:0] word;
        dq_result_t            predicted;
        word = '0;
        word[0 +: MODE_BITS] = md;
        word[MODE_BITS +: VALUE_BITS] = val;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_command(md, val);
        expected_results.push_back(typed ? typed_res : predicted);
        words_sent++;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (rx_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        dq_result_t got;
        dq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.front_word  = m_tdata[0 +: OUT_WORD];
            got.back_word   = m_tdata[OUT_WORD +: OUT_WORD];
            got.entry_count = m_tdata[2*OUT_WORD +: COUNT_BITS];
            got.is_empty    = m_tdata[2*OUT_WORD + COUNT_BITS];
            got.status      = m_tdata[2*OUT_WORD + COUNT_BITS + 1 +: STATUS_BITS];
            if (expected_results.size() == 0)
                report_mismatch("result word with nothing expected", got.front_word, '0);
            else
            begin
                want = expected_results.pop_front();
                if (got.front_word !== want.front_word)
                    report_mismatch("front_word", got.front_word, want.front_word);
                if (got.back_word !== want.back_word)
                    report_mismatch("back_word", got.back_word, want.back_word);
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", got.entry_count, want.entry_count);
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", got.is_empty, want.is_empty);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
    end

    initial
    begin : stimulus
        int   i;
        int   guard;
        logic paused;
        logic held;
        paused = 1'b0;
        held   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_word(directed_rows[i].mode, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].res);

        while (words_sent < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            if (!paused && words_sent >= PAUSE_AT)
            begin
                // let every outstanding word come back before going on
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_results.size() != 0);
            end
            if (!held && words_sent >= HOLD_AT)
            begin
                held = 1'b1;
                rx_hold = 1'b1;
            end
            quiet = (words_sent >= QUIET_AFTER);
            case ($urandom_range(0, 3))
                0:
                begin
                    // fill to the brim, then push into a full ring
                    while (shadow_count < DEPTH)
                        send_word(($urandom_range(0, 9) == 0) ? MODE_REVERSE : push_mode(),
                                  rand_word(), 1'b0, '0);
                    repeat ($urandom_range(1, 4)) send_word(push_mode(), rand_word(), 1'b0, '0);
                end
                1:
                begin
                    while (shadow_count != 0)
                        send_word(($urandom_range(0, 9) == 0) ? pick_mode() : pop_mode(),
                                  rand_word(), 1'b0, '0);
                    repeat ($urandom_range(1, 3)) send_word(pop_mode(), rand_word(), 1'b0, '0);
                    send_word(MODE_REVERSE, rand_word(), 1'b0, '0);
                end
                default:
                    repeat ($urandom_range(20, 60)) send_word(pick_mode(), rand_word(), 1'b0, '0);
            endcase
        end
        s_tvalid <= 1'b0;

        guard = 0;
        while (expected_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("expected words left over", expected_results.size(), '0);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
